@@ hdl/sfm_pkg.sv @@
`default_nettype none
package sfm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int POS_OUT_BITS   = 11;
    localparam int SIZE_BITS      = 12;
    localparam int LINES          = 6;
    localparam int TAPS           = 7;
    localparam int MAX_RUN        = 4;
    localparam int FIFO_DEPTH     = 8;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_DIRECTION    = 3'd2,
        REG_COEF_OUTER   = 3'd3,
        REG_COEF_MIDDLE  = 3'd4,
        REG_COEF_INNER   = 3'd5,
        REG_COEF_CENTER  = 3'd6
    } t_reg_index;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [TAPS-1:0] t_taps;

    typedef struct packed {
        logic [COEF_BITS-1:0] outer;
        logic [COEF_BITS-1:0] middle;
        logic [COEF_BITS-1:0] inner;
        logic [COEF_BITS-1:0] center;
    } t_coefs;

    typedef struct packed {
        logic [POS_OUT_BITS-1:0] row;
        logic [POS_OUT_BITS-1:0] col;
        logic                    last;
    } t_meta;

    typedef struct packed {
        t_sample value;
        t_meta   meta;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/symmetric_fir7_mirror_border.sv @@
// Symmetric 7-tap filter over a raster-order image, along rows (direction 0) or
// along columns (direction 1), with borders mirrored, edge sample repeated. Six
// cells each hold one tap of the row window and one line of the column store
// (MAX_WIDTH words each); one word is taken per cycle while o_stall is low. A
// word that completes a row (direction 0) or any word of the last row
// (direction 1) yields four results, emitted one per cycle by the output
// sequencer while the output queue has space; o_stall holds the next word until
// the last is emitted. An eight-entry output queue decouples the output stall.
// Writing the width or height restarts the frame at row 0, column 0.
// Coefficients are unsigned Q1.15, sum rounded half up and saturated to 16
// bits. No clearing pass after reset is needed.
`default_nettype none
module symmetric_fir7_mirror_border #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data,
    input  wire                  i_valid,
    input  wire  signed [15:0]   i_pixel_value,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic signed [15:0]   o_filtered_value,
    output logic [10:0]          o_out_row,
    output logic [10:0]          o_out_col,
    output logic                 o_last_of_run
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int PW = ((AW > HW) ? AW : HW) + 1;
    localparam int SW = PW + 3;
    localparam int L  = sfm_pkg::LINES;
    localparam int NR = sfm_pkg::MAX_RUN;

    logic [sfm_pkg::SIZE_BITS-1:0] r_width, r_height;
    logic                          r_dir;
    sfm_pkg::t_coefs               r_coefs;

    logic [PW-1:0] r_col, r_row;
    logic [2:0]    r_rm;

    logic [PW-1:0] w, h, c, r, c1, r1;
    logic [2:0]    rm, rm1;
    logic          acc;

    always_comb begin
        logic [13:0] ww, hh;
        ww = 14'(r_width);
        hh = 14'(r_height);
        w  = PW'((ww < 14'd6) ? 14'd6 : ((ww > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : ww));
        h  = PW'((hh < 14'd6) ? 14'd6 : ((hh > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : hh));
    end

    always_comb begin
        c   = (r_col >= w) ? '0 : r_col;
        r   = (r_row >= h) ? '0 : r_row;
        rm  = (r_row >= h) ? '0 : r_rm;
        c1  = c + PW'(1);
        r1  = r;
        rm1 = rm;
        if (c1 >= w) begin
            c1  = '0;
            r1  = r + PW'(1);
            rm1 = (rm == 3'(L - 1)) ? '0 : rm + 3'd1;
            if (r1 >= h) begin
                r1  = '0;
                rm1 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_dir    <= 1'b0;
            r_coefs  <= '{outer: 16'd0, middle: 16'd0, inner: 16'd0, center: 16'd32768};
            r_col    <= '0;
            r_row    <= '0;
            r_rm     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfm_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[11:0];
                    r_col   <= '0;
                    r_row   <= '0;
                    r_rm    <= '0;
                end
                sfm_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[11:0];
                    r_col    <= '0;
                    r_row    <= '0;
                    r_rm     <= '0;
                end
                sfm_pkg::REG_DIRECTION:   r_dir          <= i_cfg_data[0];
                sfm_pkg::REG_COEF_OUTER:  r_coefs.outer  <= i_cfg_data;
                sfm_pkg::REG_COEF_MIDDLE: r_coefs.middle <= i_cfg_data;
                sfm_pkg::REG_COEF_INNER:  r_coefs.inner  <= i_cfg_data;
                sfm_pkg::REG_COEF_CENTER: r_coefs.center <= i_cfg_data;
                default: ;
            endcase
        end else if (acc) begin
            r_col <= c1;
            r_row <= r1;
            r_rm  <= rm1;
        end
    end

    // cell chain: tap window and line banks
    sfm_pkg::t_sample tap  [L];
    sfm_pkg::t_sample line [L];

    for (genvar g = 0; g < L; g++) begin : g_cell
        sfm_cell #(.AW(AW), .DEPTH(MAX_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (acc),
            .i_prev  ((g == 0) ? i_pixel_value : tap[(g == 0) ? 0 : g - 1]),
            .o_tap   (tap[g]),
            .i_we    (rm == 3'(g)),
            .i_addr  (c[AW-1:0]),
            .i_wdata (i_pixel_value),
            .o_rdata (line[g])
        );
    end

    // word stage
    logic             r_s1_v;
    sfm_pkg::t_sample r_s1_s;
    sfm_pkg::t_sample r_s1_win [L];
    logic [PW-1:0]    r_s1_c, r_s1_r;
    logic [2:0]       r_s1_rm;

    // output sequencer
    sfm_pkg::t_taps   r_job_taps [NR];
    sfm_pkg::t_meta   r_job_meta [NR];
    logic [2:0]       r_job_rem;
    logic [1:0]       r_job_idx;

    logic             emit, done, load, space;
    logic [1:0]       inflight;
    sfm_pkg::t_taps   n_taps [NR];
    sfm_pkg::t_meta   n_meta [NR];
    logic [2:0]       n_cnt;
    sfm_pkg::t_meta   emit_meta;

    always_comb begin
        sfm_pkg::t_sample    hist [L+1];
        logic [3:0]          bidx;
        logic signed [SW-1:0] pos, n, i, j, back, k;
        hist[0] = r_s1_s;
        for (int b = 1; b <= L; b++) begin
            bidx = 4'(r_s1_rm) + 4'(L - b);
            if (bidx >= 4'(L)) begin
                bidx = bidx - 4'(L);
            end
            hist[b] = r_dir ? line[bidx[2:0]] : r_s1_win[b-1];
        end
        pos = r_dir ? SW'(r_s1_r) : SW'(r_s1_c);
        n   = r_dir ? SW'(h) : SW'(w);
        if (pos < SW'(3)) begin
            n_cnt = 3'd0;
        end else if (pos == n - SW'(1)) begin
            n_cnt = 3'(NR);
        end else begin
            n_cnt = 3'd1;
        end
        for (int kk = 0; kk < NR; kk++) begin
            k = pos - SW'(3) + SW'(kk);
            for (int d = 0; d < sfm_pkg::TAPS; d++) begin
                i = k + SW'(d) - SW'(3);
                if (i < 0) begin
                    j = -i - SW'(1);
                end else if (i >= n) begin
                    j = SW'(2) * n - SW'(1) - i;
                end else begin
                    j = i;
                end
                back = pos - j;
                if (back >= 0 && back <= SW'(L)) begin
                    n_taps[kk][d] = hist[back[2:0]];
                end else begin
                    n_taps[kk][d] = '0;
                end
            end
            n_meta[kk].row  = r_dir ? 11'(k) : 11'(r_s1_r);
            n_meta[kk].col  = r_dir ? 11'(r_s1_c) : 11'(k);
            n_meta[kk].last = (3'(kk) == n_cnt - 3'd1);
        end
    end

    logic [3:0] r_cnt;
    assign space   = (r_cnt + 4'(inflight)) < 4'(sfm_pkg::FIFO_DEPTH);
    assign emit    = (r_job_rem != 3'd0) && space;
    assign done    = (r_job_rem == 3'd0) || (emit && r_job_rem == 3'd1);
    assign load    = r_s1_v && done;
    assign o_stall = r_s1_v && !done;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_s  <= i_pixel_value;
            r_s1_c  <= c;
            r_s1_r  <= r;
            r_s1_rm <= rm;
            for (int b = 0; b < L; b++) begin
                r_s1_win[b] <= tap[b];
            end
        end
        if (load) begin
            for (int kk = 0; kk < NR; kk++) begin
                r_job_taps[kk] <= n_taps[kk];
                r_job_meta[kk] <= n_meta[kk];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_job_rem <= '0;
            r_job_idx <= '0;
        end else begin
            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (load) begin
                r_s1_v <= 1'b0;
            end
            if (load) begin
                r_job_rem <= n_cnt;
                r_job_idx <= '0;
            end else if (emit) begin
                r_job_rem <= r_job_rem - 3'd1;
                r_job_idx <= r_job_idx + 2'd1;
            end
        end
    end

    assign emit_meta = r_job_meta[r_job_idx];

    logic             mac_v;
    sfm_pkg::t_result mac_res;

    sfm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (emit),
        .i_taps     (r_job_taps[r_job_idx]),
        .i_meta     (emit_meta),
        .i_coefs    (r_coefs),
        .o_valid    (mac_v),
        .o_result   (mac_res),
        .o_inflight (inflight)
    );

    // output queue
    sfm_pkg::t_result r_fifo [sfm_pkg::FIFO_DEPTH];
    logic [2:0]       r_wp, r_rp;
    logic             pop;

    assign o_valid = (r_cnt != 4'd0);
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (mac_v) begin
            r_fifo[r_wp] <= mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (mac_v) begin
                r_wp <= r_wp + 3'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 3'd1;
            end
            r_cnt <= r_cnt + 4'(mac_v) - 4'(pop);
        end
    end

    assign o_filtered_value = r_fifo[r_rp].value;
    assign o_out_row        = r_fifo[r_rp].meta.row;
    assign o_out_col        = r_fifo[r_rp].meta.col;
    assign o_last_of_run    = r_fifo[r_rp].meta.last;

endmodule
`default_nettype wire

@@ hdl/sfm_cell.sv @@
`default_nettype none
module sfm_cell #(
    parameter int AW    = 11,
    parameter int DEPTH = 2048
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  sfm_pkg::t_sample     i_prev,
    output sfm_pkg::t_sample     o_tap,
    input  wire                  i_we,
    input  wire  [AW-1:0]        i_addr,
    input  sfm_pkg::t_sample     i_wdata,
    output sfm_pkg::t_sample     o_rdata
);

    sfm_pkg::t_sample r_tap;
    sfm_pkg::t_sample r_rdata;
    sfm_pkg::t_sample r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_shift) begin
            r_tap <= i_prev;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_shift && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_shift) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_tap   = r_tap;
    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/sfm_mac.sv @@
`default_nettype none
module sfm_mac (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  sfm_pkg::t_taps       i_taps,
    input  sfm_pkg::t_meta       i_meta,
    input  sfm_pkg::t_coefs      i_coefs,
    output logic                 o_valid,
    output sfm_pkg::t_result     o_result,
    output logic [1:0]           o_inflight
);

    localparam int PB = sfm_pkg::SAMPLE_BITS + 1;
    localparam int MB = PB + sfm_pkg::COEF_BITS + 1;
    localparam int AB = MB + 2;
    localparam int QB = AB - sfm_pkg::COEF_FRAC_BITS;
    localparam logic signed [QB-1:0] SAT_MAX = QB'((1 << (sfm_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [QB-1:0] SAT_MIN = -QB'(1 << (sfm_pkg::SAMPLE_BITS - 1));

    logic                  r_v1, r_v2;
    logic signed [MB-1:0]  r_prod [4];
    sfm_pkg::t_meta        r_meta1;
    sfm_pkg::t_result      r_res;

    logic signed [PB-1:0]  n_pair [4];
    logic signed [AB-1:0]  n_sum;
    logic signed [QB-1:0]  n_q;
    sfm_pkg::t_sample      n_sat;

    always_comb begin
        n_pair[0] = PB'(i_taps[0]) + PB'(i_taps[6]);
        n_pair[1] = PB'(i_taps[1]) + PB'(i_taps[5]);
        n_pair[2] = PB'(i_taps[2]) + PB'(i_taps[4]);
        n_pair[3] = PB'(i_taps[3]);
    end

    always_ff @(posedge i_clk) begin
        r_prod[0] <= MB'(n_pair[0]) * MB'($signed({1'b0, i_coefs.outer}));
        r_prod[1] <= MB'(n_pair[1]) * MB'($signed({1'b0, i_coefs.middle}));
        r_prod[2] <= MB'(n_pair[2]) * MB'($signed({1'b0, i_coefs.inner}));
        r_prod[3] <= MB'(n_pair[3]) * MB'($signed({1'b0, i_coefs.center}));
        r_meta1   <= i_meta;
        r_res     <= '{value: n_sat, meta: r_meta1};
    end

    always_comb begin
        n_sum = AB'(r_prod[0]) + AB'(r_prod[1]) + AB'(r_prod[2]) + AB'(r_prod[3])
              + AB'(1 << (sfm_pkg::COEF_FRAC_BITS - 1));
        n_q   = QB'(n_sum >>> sfm_pkg::COEF_FRAC_BITS);
        if (n_q > SAT_MAX) begin
            n_sat = SAT_MAX[sfm_pkg::SAMPLE_BITS-1:0];
        end else if (n_q < SAT_MIN) begin
            n_sat = SAT_MIN[sfm_pkg::SAMPLE_BITS-1:0];
        end else begin
            n_sat = n_q[sfm_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid    = r_v2;
    assign o_result   = r_res;
    assign o_inflight = 2'(r_v1) + 2'(r_v2);

endmodule
`default_nettype wire

@@ test/tb_symmetric_fir7_mirror_border.sv @@
`default_nettype none
module tb_symmetric_fir7_mirror_border;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int PIX_W = 2048;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic signed [15:0] i_pixel_value = '0;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [15:0] o_filtered_value;
    logic [10:0]        o_out_row;
    logic [10:0]        o_out_col;
    logic               o_last_of_run;

    symmetric_fir7_mirror_border u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_pixel_value(i_pixel_value), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_filtered_value(o_filtered_value),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_last_of_run(o_last_of_run)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block
    logic [11:0]      img_w, img_h;
    logic             dir_cols;
    logic [15:0]      c_outer, c_middle, c_inner, c_center;
    sfm_pkg::t_sample row_win [6];
    sfm_pkg::t_sample line_mem [sfm_pkg::LINES][PIX_W];
    int               col_cnt, row_cnt;

    sfm_pkg::t_result fresh_results[$];
    sfm_pkg::t_result pending_results[$];
    int      errors = 0;
    int      mismatches = 0;
    bit      hold_req = 0;
    bit      no_gaps = 0;

    function automatic int clamp_size(int v);
        return (v < 6) ? 6 : (v > PIX_W) ? PIX_W : v;
    endfunction

    function automatic int mirror_idx(int i, int n);
        if (i < 0) return -i - 1;
        if (i >= n) return 2 * n - 1 - i;
        return i;
    endfunction

    function automatic sfm_pkg::t_sample fir_sum(longint p[7]);
        longint acc;
        acc = longint'(c_outer) * (p[0] + p[6]) + longint'(c_middle) * (p[1] + p[5])
            + longint'(c_inner) * (p[2] + p[4]) + longint'(c_center) * p[3];
        acc = (acc + 64'sd16384) >>> sfm_pkg::COEF_FRAC_BITS;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return sfm_pkg::t_sample'(acc);
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] v);
        case (idx)
            sfm_pkg::REG_IMAGE_WIDTH:  begin img_w = v[11:0]; col_cnt = 0; row_cnt = 0; end
            sfm_pkg::REG_IMAGE_HEIGHT: begin img_h = v[11:0]; col_cnt = 0; row_cnt = 0; end
            sfm_pkg::REG_DIRECTION:    dir_cols = v[0];
            sfm_pkg::REG_COEF_OUTER:   c_outer = v;
            sfm_pkg::REG_COEF_MIDDLE:  c_middle = v;
            sfm_pkg::REG_COEF_INNER:   c_inner = v;
            sfm_pkg::REG_COEF_CENTER:  c_center = v;
            default: ;
        endcase
    endfunction

    function automatic void filter_pixel(sfm_pkg::t_sample s);
        int w, h, c, r, first, lst, j, back;
        longint taps[7];
        sfm_pkg::t_result res;
        w = clamp_size(img_w);
        h = clamp_size(img_h);
        c = (col_cnt >= w) ? 0 : col_cnt;
        r = (row_cnt >= h) ? 0 : row_cnt;
        if (!dir_cols && c >= 3) begin
            first = c - 3;
            lst = (c == w - 1) ? w - 1 : first;
            for (int k = first; k <= lst; k++) begin
                for (int d = 0; d < 7; d++) begin
                    j = mirror_idx(k + d - 3, w);
                    back = c - j;
                    if (j == c) taps[d] = s;
                    else taps[d] = (back >= 1 && back <= 6) ? row_win[back-1] : 0;
                end
                res.value = fir_sum(taps);
                res.meta = '{row: r[10:0], col: k[10:0], last: (k == lst)};
                fresh_results.push_back(res);
            end
        end else if (dir_cols && r >= 3) begin
            first = r - 3;
            lst = (r == h - 1) ? h - 1 : first;
            for (int k = first; k <= lst; k++) begin
                for (int d = 0; d < 7; d++) begin
                    j = mirror_idx(k + d - 3, h);
                    taps[d] = (j == r) ? longint'(s)
                                       : longint'(line_mem[j % sfm_pkg::LINES][c]);
                end
                res.value = fir_sum(taps);
                res.meta = '{row: k[10:0], col: c[10:0], last: (k == lst)};
                fresh_results.push_back(res);
            end
        end
        line_mem[r % sfm_pkg::LINES][c] = s;
        for (int i = 5; i > 0; i--) row_win[i] = row_win[i-1];
        row_win[0] = s;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        apply_reg(idx, v);
    endtask

    task automatic set_config(logic [15:0] w, logic [15:0] h, logic dir,
                              logic [15:0] co, logic [15:0] cm, logic [15:0] ci,
                              logic [15:0] cc);
        cfg_write(sfm_pkg::REG_IMAGE_WIDTH, w);
        cfg_write(sfm_pkg::REG_IMAGE_HEIGHT, h);
        cfg_write(sfm_pkg::REG_DIRECTION, {15'd0, dir});
        cfg_write(sfm_pkg::REG_COEF_OUTER, co);
        cfg_write(sfm_pkg::REG_COEF_MIDDLE, cm);
        cfg_write(sfm_pkg::REG_COEF_INNER, ci);
        cfg_write(sfm_pkg::REG_COEF_CENTER, cc);
        i_cfg_we <= 1'b0;
    endtask

    // drives one word, returns after the edge that accepts it; valid stays high
    task automatic send_word(sfm_pkg::t_sample s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic sfm_pkg::t_sample rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return sfm_pkg::t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 12000));
        endcase
    endfunction

    typedef struct {
        sfm_pkg::t_sample s;
        bit               typed;
        sfm_pkg::t_sample value;
    } t_dir_row;

    // reset setup: center weight one, along rows, width 640
    t_dir_row dir_rows[12] = '{
        '{16'sd5, 0, 16'sd0},       '{-16'sd7, 0, 16'sd0},      '{16'sd100, 0, 16'sd0},
        '{16'sh7FFF, 1, 16'sd5},    '{16'sh8000, 1, -16'sd7},   '{16'sd0, 1, 16'sd100},
        '{-16'sd1, 1, 16'sh7FFF},   '{16'sd1, 1, 16'sh8000},    '{16'sh5555, 1, 16'sd0},
        '{16'shAAAA, 1, -16'sd1},   '{16'sd12345, 1, 16'sd1},   '{-16'sd12345, 1, 16'sh5555}
    };

    initial begin
        int total, n_items;
        sfm_pkg::t_result res;
        apply_reg(sfm_pkg::REG_IMAGE_WIDTH, 16'd640);
        apply_reg(sfm_pkg::REG_IMAGE_HEIGHT, 16'd480);
        apply_reg(sfm_pkg::REG_DIRECTION, 16'd0);
        apply_reg(sfm_pkg::REG_COEF_OUTER, 16'd0);
        apply_reg(sfm_pkg::REG_COEF_MIDDLE, 16'd0);
        apply_reg(sfm_pkg::REG_COEF_INNER, 16'd0);
        apply_reg(sfm_pkg::REG_COEF_CENTER, 16'd32768);
        for (int i = 0; i < 6; i++) row_win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(REG_UNUSED, 16'hFFFF);
        i_cfg_we <= 1'b0;
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].s);
            filter_pixel(dir_rows[i].s);
            if (dir_rows[i].typed) begin
                fresh_results.delete();
                res.value = dir_rows[i].value;
                res.meta = '{row: 11'd0, col: 11'(i - 3), last: 1'b1};
                pending_results.push_back(res);
            end else begin
                while (fresh_results.size() > 0) pending_results.push_back(fresh_results.pop_front());
            end
        end
        drain();

        total = 0;
        for (int ph = 0; total < 360; ph++) begin
            case (ph)
                0: set_config(16'hFFFF, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_config(16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd32768);
                2: set_config(16'd6, 16'd6, 1'b1, 16'd4096, 16'd8192, 16'd12288, 16'd32768);
                default: set_config(16'($urandom_range(6, 12)), 16'($urandom_range(6, 9)),
                                    1'($urandom_range(0, 1)), rand_coef(), rand_coef(),
                                    rand_coef(), rand_coef());
            endcase
            no_gaps = (ph == 3) || ($urandom_range(0, 3) == 0);
            hold_req = (ph == 3);
            n_items = (ph < 2) ? 40 : $urandom_range(20, 60);
            for (int i = 0; i < n_items; i++) begin
                res.value = rand_pixel();
                send_word(res.value);
                filter_pixel(res.value);
                while (fresh_results.size() > 0) pending_results.push_back(fresh_results.pop_front());
            end
            total += n_items;
            drain();
        end

        if (errors == 0 && pending_results.size() == 0)
            $display("[symmetric_fir7_mirror_border] OK");
        else
            $display("[symmetric_fir7_mirror_border] ERROR");
        $finish;
    end

    // output side: random stall per word, one long hold-off on request
    initial begin
        int n;
        sfm_pkg::t_result exp_res;
        @(posedge i_rst_n);
        forever begin
            n = hold_req ? 300 : (no_gaps ? 0 : $urandom_range(0, 19));
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                hold_req = 0;
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected word: value %0d row %0d col %0d", o_filtered_value,
                             o_out_row, o_out_col);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_filtered_value !== exp_res.value || o_out_row !== exp_res.meta.row ||
                    o_out_col !== exp_res.meta.col || o_last_of_run !== exp_res.meta.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp %0d r%0d c%0d l%0d, got %0d r%0d c%0d l%0d",
                                 exp_res.value, exp_res.meta.row, exp_res.meta.col,
                                 exp_res.meta.last, o_filtered_value, o_out_row, o_out_col,
                                 o_last_of_run);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("[symmetric_fir7_mirror_border] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
